### sv/mcpt_pkg.sv
// Shared types and constants for the multichannel period tachometer.
// Depends on nothing; used by mcpt_div and multichannel_period_tachometer.
package mcpt_pkg;

   // Field widths fixed by the item formats
   localparam int CHAN_BITS      = 4;
   localparam int STAMP_IN_BITS  = 16;
   localparam int NUM_BITS       = 20;
   localparam int MINP_BITS      = 16;
   localparam int LIMIT_BITS     = 8;
   localparam int MASK_BITS      = 9;
   localparam int STATUS_BITS    = 2;
   localparam int CSR_INDEX_BITS = 2;
   localparam int REQ_TDATA_BITS = 24;
   localparam int RSP_TDATA_BITS = 40;

   // Register reset values
   localparam logic [NUM_BITS-1:0]   NUM_RESET    = 20'd300000;
   localparam logic [MINP_BITS-1:0]  MINP_RESET   = 16'd100;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET  = 8'd10;
   localparam logic [MASK_BITS-1:0]  ENABLE_RESET = 9'h1FF;
   localparam logic [LIMIT_BITS-1:0] STALL_MAX    = 8'hFF;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_UPDATED  = 2'd0,
      STATUS_GLITCH   = 2'd1,
      STATUS_DISABLED = 2'd2,
      STATUS_TICK     = 2'd3
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_NUMERATOR      = 2'd0,
      CSR_MIN_PERIOD     = 2'd1,
      CSR_STALL_LIMIT    = 2'd2,
      CSR_CHANNEL_ENABLE = 2'd3
   } csr_index_type;

endpackage

### sv/mcpt_div.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on mcpt_pkg for the dividend width.
module mcpt_div #(
   parameter int DIV_BITS = 17
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [mcpt_pkg::NUM_BITS-1:0] dividend,
   input  logic [DIV_BITS-1:0]           divisor,
   output logic                          done,
   output logic [mcpt_pkg::NUM_BITS-1:0] quotient
);
   localparam int CNT_BITS = $clog2(mcpt_pkg::NUM_BITS);

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [CNT_BITS-1:0]           count_ff, count_in;
   logic [DIV_BITS-1:0]           rem_ff, rem_in;
   logic [mcpt_pkg::NUM_BITS-1:0] dvd_ff, dvd_in;
   logic [DIV_BITS:0]             trial;
   logic                          fits;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      dvd_in   = dvd_ff;
      // shift the next dividend bit into the partial remainder
      trial    = {rem_ff, dvd_ff[mcpt_pkg::NUM_BITS-1]};
      fits     = (trial >= {1'b0, divisor});
      if (start) begin
         busy_in  = 1'b1;
         count_in = CNT_BITS'(mcpt_pkg::NUM_BITS - 1);
         rem_in   = '0;
         dvd_in   = dividend;
      end else if (busy_ff) begin
         rem_in = fits ? DIV_BITS'(trial - {1'b0, divisor}) : DIV_BITS'(trial);
         dvd_in = {dvd_ff[mcpt_pkg::NUM_BITS-2:0], fits};
         if (count_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      rem_ff   <= rem_in;
      dvd_ff   <= dvd_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

### sv/multichannel_period_tachometer.sv
// Top level of the multichannel period tachometer: channel state, sequencer,
// result register. Depends on mcpt_pkg and mcpt_div.
//
// Usage:
//   req_*  input words: tuser = op (0 capture, 1 tick); tdata = channel and
//          timer stamp. A capture measures the period since the channel's last
//          accepted stamp and turns it into a speed; a tick ages every enabled
//          channel's stall counter and zeroes the speed of stalled channels.
//   rsp_*  one result word per input word: channel, speed, status, stall mask.
//   csr_*  register writes (numerator, minimum period, stall limit, enable
//          mask); always ready, write only while the block is idle.
// Sequencing: one word is in work at a time. A valid capture passes S_CALC,
// S_PCHK and S_DIV before S_SEND; its time is set by the bit-serial divider
// that retires one quotient bit per cycle over the 20 dividend bits. Ticks and
// disabled channels go from S_CALC straight to S_SEND, glitches via S_PCHK. The
// next word is accepted the cycle after the result moves to the output register.
// Reset: registers return to their defaults, all stamps, speeds and stall
// counters clear, and the output register empties.
// Stall: a result waiting on rsp_tready holds in the output register while the
// next word is accepted and worked on; that word then waits until the output
// register frees up.
module multichannel_period_tachometer #(
   parameter int CHANNELS   = 9,
   parameter int STAMP_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration write channel
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mcpt_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [mcpt_pkg::NUM_BITS-1:0]         csr_data,
   // input words
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [mcpt_pkg::REQ_TDATA_BITS-1:0]   req_tdata,  // channel[3:0], timestamp[19:4]
   input  logic                                  req_tuser,  // op[0]
   // result words
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [mcpt_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata,  // out_channel[3:0], speed[23:4],
                                                             // stalled_mask[32:24]
   output logic [mcpt_pkg::STATUS_BITS-1:0]      rsp_tuser   // status[1:0]
);
   // stored stamp width, period width (holds the full wrap), compare width
   localparam int SW  = (STAMP_BITS < mcpt_pkg::STAMP_IN_BITS) ? STAMP_BITS
                                                               : mcpt_pkg::STAMP_IN_BITS;
   localparam int PW  = STAMP_BITS + 1;
   localparam int CW  = (PW > mcpt_pkg::MINP_BITS) ? PW : mcpt_pkg::MINP_BITS;
   localparam int CIW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int NB  = mcpt_pkg::NUM_BITS;
   localparam int LB  = mcpt_pkg::LIMIT_BITS;
   localparam int MB  = mcpt_pkg::MASK_BITS;
   localparam int CB  = mcpt_pkg::CHAN_BITS;

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_CALC = 5'b00010,
      S_PCHK = 5'b00100,
      S_DIV  = 5'b01000,
      S_SEND = 5'b10000
   } state_type;

   state_type state_ff, state_in;

   // configuration registers
   logic [NB-1:0]                  numerator_ff, numerator_in;
   logic [mcpt_pkg::MINP_BITS-1:0] min_period_ff, min_period_in;
   logic [LB-1:0]                  stall_limit_ff, stall_limit_in;
   logic [MB-1:0]                  enable_ff, enable_in;

   // per-channel state
   logic [SW-1:0] last_stamp_ff [CHANNELS];
   logic [SW-1:0] last_stamp_in [CHANNELS];
   logic [NB-1:0] speed_ff      [CHANNELS];
   logic [NB-1:0] speed_in      [CHANNELS];
   logic [LB-1:0] stall_ff      [CHANNELS];
   logic [LB-1:0] stall_in      [CHANNELS];

   // word in work
   logic                  op_ff, op_in;
   logic [CB-1:0]         ch_ff, ch_in;
   logic [SW-1:0]         stamp_ff, stamp_in;
   logic [PW-1:0]         period_ff, period_in;
   logic [CB-1:0]         res_chan_ff, res_chan_in;
   logic [NB-1:0]         res_speed_ff, res_speed_in;
   mcpt_pkg::status_type  res_status_ff, res_status_in;

   // output register
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [mcpt_pkg::RSP_TDATA_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic [mcpt_pkg::STATUS_BITS-1:0]   rsp_user_ff, rsp_user_in;

   logic                  div_start;
   logic                  div_done;
   logic [NB-1:0]         div_quotient;
   logic [CHANNELS-1:0]   en_vec;
   logic [MB-1:0]         stalled_mask;
   logic [CIW-1:0]        ch_idx;
   logic                  chan_ok;
   logic [STAMP_BITS-1:0] diff;
   logic [LB-1:0]         bumped;
   logic                  out_free;

   mcpt_div #(
      .DIV_BITS(PW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (numerator_ff),
      .divisor  (period_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   // enable per channel; channels without an enable bit stay off
   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         en_vec[i] = (i < MB) ? enable_ff[i % MB] : 1'b0;
      end
      for (int i = 0; i < MB; i++) begin
         stalled_mask[i] = (i < CHANNELS) ? (stall_ff[i % CHANNELS] >= stall_limit_ff)
                                          : 1'b0;
      end
   end

   assign ch_idx   = ch_ff[CIW-1:0];
   assign chan_ok  = (int'(ch_ff) < CHANNELS) && en_vec[ch_idx];
   assign diff     = STAMP_BITS'(stamp_ff) - STAMP_BITS'(last_stamp_ff[ch_idx]);
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in       = state_ff;
      numerator_in   = numerator_ff;
      min_period_in  = min_period_ff;
      stall_limit_in = stall_limit_ff;
      enable_in      = enable_ff;
      last_stamp_in  = last_stamp_ff;
      speed_in       = speed_ff;
      stall_in       = stall_ff;
      op_in          = op_ff;
      ch_in          = ch_ff;
      stamp_in       = stamp_ff;
      period_in      = period_ff;
      res_chan_in    = res_chan_ff;
      res_speed_in   = res_speed_ff;
      res_status_in  = res_status_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_data_in    = rsp_data_ff;
      rsp_user_in    = rsp_user_ff;
      div_start      = 1'b0;
      bumped         = '0;

      // register writes
      if (csr_valid) begin
         unique case (mcpt_pkg::csr_index_type'(csr_index))
            mcpt_pkg::CSR_NUMERATOR:      numerator_in   = csr_data;
            mcpt_pkg::CSR_MIN_PERIOD:     min_period_in  = csr_data[mcpt_pkg::MINP_BITS-1:0];
            mcpt_pkg::CSR_STALL_LIMIT:    stall_limit_in = csr_data[LB-1:0];
            mcpt_pkg::CSR_CHANNEL_ENABLE: enable_in      = csr_data[MB-1:0];
            default: ;
         endcase
      end

      // drop a delivered result
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               op_in    = req_tuser;
               ch_in    = req_tdata[CB-1:0];
               stamp_in = req_tdata[CB+SW-1:CB];
               state_in = S_CALC;
            end
         end
         S_CALC: begin
            if (op_ff) begin
               // age every enabled channel, zero the speed of stalled ones
               for (int i = 0; i < CHANNELS; i++) begin
                  bumped = (stall_ff[i] < mcpt_pkg::STALL_MAX) ? stall_ff[i] + 1'b1
                                                               : stall_ff[i];
                  if (en_vec[i]) begin
                     stall_in[i] = bumped;
                     if (bumped >= stall_limit_ff) begin
                        speed_in[i] = '0;
                     end
                  end
               end
               res_chan_in   = '0;
               res_speed_in  = '0;
               res_status_in = mcpt_pkg::STATUS_TICK;
               state_in      = S_SEND;
            end else if (!chan_ok) begin
               res_chan_in   = ch_ff;
               res_speed_in  = '0;
               res_status_in = mcpt_pkg::STATUS_DISABLED;
               state_in      = S_SEND;
            end else begin
               // equal stamps count as a full wrap
               period_in = (diff == '0) ? (PW'(1) << STAMP_BITS) : PW'(diff);
               state_in  = S_PCHK;
            end
         end
         S_PCHK: begin
            res_chan_in = ch_ff;
            if (CW'(period_ff) < CW'(min_period_ff)) begin
               res_speed_in  = speed_ff[ch_idx];
               res_status_in = mcpt_pkg::STATUS_GLITCH;
               state_in      = S_SEND;
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               speed_in[ch_idx]      = div_quotient;
               last_stamp_in[ch_idx] = stamp_ff;
               stall_in[ch_idx]      = '0;
               res_speed_in          = div_quotient;
               res_status_in         = mcpt_pkg::STATUS_UPDATED;
               state_in              = S_SEND;
            end
         end
         S_SEND: begin
            // stall mask reflects the state after this word's update
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = mcpt_pkg::RSP_TDATA_BITS'({stalled_mask, res_speed_ff,
                                                         res_chan_ff});
               rsp_user_in  = res_status_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         numerator_ff   <= mcpt_pkg::NUM_RESET;
         min_period_ff  <= mcpt_pkg::MINP_RESET;
         stall_limit_ff <= mcpt_pkg::LIMIT_RESET;
         enable_ff      <= mcpt_pkg::ENABLE_RESET;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            last_stamp_ff[i] <= '0;
            speed_ff[i]      <= '0;
            stall_ff[i]      <= '0;
         end
      end else begin
         state_ff       <= state_in;
         numerator_ff   <= numerator_in;
         min_period_ff  <= min_period_in;
         stall_limit_ff <= stall_limit_in;
         enable_ff      <= enable_in;
         rsp_valid_ff   <= rsp_valid_in;
         last_stamp_ff  <= last_stamp_in;
         speed_ff       <= speed_in;
         stall_ff       <= stall_in;
      end
      op_ff         <= op_in;
      ch_ff         <= ch_in;
      stamp_ff      <= stamp_in;
      period_ff     <= period_in;
      res_chan_ff   <= res_chan_in;
      res_speed_ff  <= res_speed_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_user_ff   <= rsp_user_in;
   end

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule
